// ===== rtl/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants, codes, types and a helper function for the free bitmap
// allocator: geometry of the word store, request and status codes.
// ----------------------------------------------------------------------------
package fba_pkg;

    // Geometry of the bitmap store
    localparam int MAX_BITS   = 4096;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = $clog2(WORD_COUNT);
    localparam int BIT_AW     = $clog2(WORD_BITS);

    // Field widths
    localparam int KIND_W   = 2;
    localparam int IDX_W    = 12;
    localparam int SIZE_W   = 13;
    localparam int STATUS_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_BITS);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_TEST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FIND  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd2;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [WORD_AW-1:0]   t_word_addr;
    typedef logic [BIT_AW-1:0]    t_bit_pos;

    // Update of the per-word summary flags after a write-back
    typedef struct packed {
        logic       en;
        t_word_addr word;
        logic       full;
    } t_sum_upd;

    // Lowest clear bit position within one word
    function automatic t_bit_pos first_zero_bit(input t_word w);
        t_bit_pos pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = BIT_AW'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== rtl/fba_ram.sv =====
// ----------------------------------------------------------------------------
// fba_ram
// Word store of the bitmap: one write port and one registered read port.
// ----------------------------------------------------------------------------
module fba_ram
    import fba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rd_en,
    input  t_word_addr i_rd_addr,
    output t_word      o_rd_data,
    input  logic       i_wr_en,
    input  t_word_addr i_wr_addr,
    input  t_word      i_wr_data
);

    t_word r_mem [WORD_COUNT];
    t_word r_rd_data;

    // Write one word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one word, hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/fba_summary.sv =====
// ----------------------------------------------------------------------------
// fba_summary
// Per-word flags beside the word store: a written flag (a word never
// written reads as all free) and a full flag that steers the search for
// the first word holding a clear bit.
// ----------------------------------------------------------------------------
module fba_summary
    import fba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_sum_upd   i_upd,
    input  t_word_addr i_chk_word,
    output logic       o_chk_written,
    output logic       o_any_open,
    output t_word_addr o_first_open
);

    logic [WORD_COUNT-1:0] r_written;
    logic [WORD_COUNT-1:0] r_full;

    // Track written and full flags; reset marks every word free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_full    <= '0;
        end else if (i_upd.en) begin
            r_written[i_upd.word] <= 1'b1;
            r_full[i_upd.word]    <= i_upd.full;
        end
    end

    assign o_chk_written = r_written[i_chk_word];

    // Find the lowest word that is not full
    always_comb begin
        o_any_open   = 1'b0;
        o_first_open = '0;
        for (int i = WORD_COUNT - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                o_any_open   = 1'b1;
                o_first_open = WORD_AW'(i);
            end
        end
    end

endmodule

// ===== rtl/free_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// free_bitmap_allocator_unit
// Requests are taken only while idle: the word is read when a request is
// accepted, then written back (set and clear) and the result registered
// once the output register is free; no new request is taken until then.
// Reset: synchronous; written/full flags clear together, so the whole
// bitmap reads free at once. Size register resets to 4096.
// ----------------------------------------------------------------------------
module free_bitmap_allocator_unit
    import fba_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration
    input  logic                i_cfg_wr_en,
    input  logic [SIZE_W-1:0]   i_cfg_wr_data,
    // Request channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [IDX_W-1:0]    i_entry_index,
    // Result channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [IDX_W-1:0]    o_result_index,
    output logic                o_bit_value
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                r_state;
    logic [SIZE_W-1:0]   r_size;
    logic [KIND_W-1:0]   r_kind;
    logic [IDX_W-1:0]    r_idx;
    t_word_addr          r_word;
    logic                r_range_err;
    logic                r_no_open;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [IDX_W-1:0]    r_result_index;
    logic                r_bit_value;

    logic                n_state;
    logic [STATUS_W-1:0] n_status;
    logic [IDX_W-1:0]    n_result_index;
    logic                n_bit_value;

    logic [SIZE_W-1:0]   size_eff;
    logic                accept;
    logic                go;
    t_word_addr          rd_addr;
    t_word               rd_data;
    t_word               cur_word;
    t_word               new_word;
    logic                wr_en;
    logic                chk_written;
    logic                any_open;
    t_word_addr          first_open;
    t_bit_pos            bit_pos;
    t_bit_pos            zero_pos;
    logic [IDX_W-1:0]    found_idx;
    t_sum_upd            sum_upd;

    // Size register; its effective value is saturated at the store's capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_size <= i_cfg_wr_data;
        end
    end

    assign size_eff = (r_size > SIZE_MAX) ? SIZE_MAX : r_size;

    // Handshake control
    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign go      = (r_state == ST_EXEC) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_EXEC;
            ST_EXEC: if (go)     n_state = ST_IDLE;
            default:             n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pick the word to read: the addressed word, or the first open word
    assign rd_addr = (i_kind == KIND_FIND) ? first_open : i_entry_index[IDX_W-1:BIT_AW];

    // Capture the request beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind      <= i_kind;
            r_idx       <= i_entry_index;
            r_word      <= rd_addr;
            r_range_err <= ({1'b0, i_entry_index} >= size_eff);
            r_no_open   <= !any_open;
        end
    end

    fba_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_word),
        .i_wr_data (new_word)
    );

    fba_summary u_summary (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_upd         (sum_upd),
        .i_chk_word    (r_word),
        .o_chk_written (chk_written),
        .o_any_open    (any_open),
        .o_first_open  (first_open)
    );

    // Modify the word; a never-written word reads as all free
    assign cur_word  = chk_written ? rd_data : '0;
    assign bit_pos   = r_idx[BIT_AW-1:0];
    assign zero_pos  = first_zero_bit(cur_word);
    assign found_idx = {r_word, zero_pos};

    always_comb begin
        new_word          = cur_word;
        new_word[bit_pos] = (r_kind == KIND_SET);
    end

    assign wr_en = go && !r_range_err && ((r_kind == KIND_SET) || (r_kind == KIND_CLEAR));

    assign sum_upd.en   = wr_en;
    assign sum_upd.word = r_word;
    assign sum_upd.full = &new_word;

    // Build the result
    always_comb begin
        n_status       = STATUS_OK;
        n_result_index = '0;
        n_bit_value    = 1'b0;
        if (r_kind == KIND_FIND) begin
            if (r_no_open || ({1'b0, found_idx} >= size_eff)) begin
                n_status = STATUS_NONE;
            end else begin
                n_result_index = found_idx;
            end
        end else if (r_range_err) begin
            n_status    = STATUS_RANGE;
            n_bit_value = (r_kind == KIND_TEST);
        end else begin
            n_result_index = r_idx;
            n_bit_value    = (r_kind == KIND_TEST) && cur_word[bit_pos];
        end
    end

    // Output register: load on go, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_status       <= n_status;
            r_result_index <= n_result_index;
            r_bit_value    <= n_bit_value;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_result_index = r_result_index;
    assign o_bit_value    = r_bit_value;

endmodule
